/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the scan code decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/psa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psa_pkg
// Types, constants and keymap ROM contents for the scan code decoder.
// ---------------------------------------------------------------------------
package psa_pkg;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [6:0] K_CTRL      = 7'h1D;
  localparam logic [6:0] K_SHIFT_L   = 7'h2A;
  localparam logic [6:0] K_SHIFT_R   = 7'h36;
  localparam logic [6:0] K_ALT       = 7'h38;
  localparam logic [6:0] K_CAPS      = 7'h3A;
  localparam logic [7:0] TABLE_LIMIT = 8'h3B;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_UNKNOWN = 1'b1;

  localparam int KEYMAP_DEPTH = 59;

  localparam logic [6:0] KEYMAP_LO [KEYMAP_DEPTH] = '{
    7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h2b, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0d, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00
  };

  localparam logic [6:0] KEYMAP_HI [KEYMAP_DEPTH] = '{
    7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
    7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0d, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
    7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00
  };

  // decoder verdict for one byte
  typedef struct packed {
    logic       emit;
    logic       kind;
    logic [6:0] char_code;
    logic       ctrl_held;
    logic       alt_held;
  } psa_res_t;

endpackage
`default_nettype wire

/* rtl/core/psa_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psa_in_if
// Scan byte channel: one raw byte plus queue-full flag per word.
// ---------------------------------------------------------------------------
interface psa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;
  logic       buffer_full;

  modport source (output valid, output scan_byte, output buffer_full, input ready);
  modport sink   (input valid, input scan_byte, input buffer_full, output ready);
endinterface
`default_nettype wire

/* rtl/core/psa_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psa_out_if
// Result channel: character or unknown-key word with modifier flags.
// ---------------------------------------------------------------------------
interface psa_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [6:0] char_code;
  logic       ctrl_held;
  logic       alt_held;

  modport source (output valid, output result_kind, output char_code,
                  output ctrl_held, output alt_held, input ready);
  modport sink   (input valid, input result_kind, input char_code,
                  input ctrl_held, input alt_held, output ready);
endinterface
`default_nettype wire

/* rtl/core/ps2_scancode_to_ascii_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ps2_scancode_to_ascii_unit
// Throughput: one scan byte per cycle; input register -> decode -> result register.
// A held result stalls the input only when the next byte also yields a result.
// Reset clears the prefix, modifier and caps flags and both valid flags.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2_scancode_to_ascii_unit
  import psa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  psa_in_if.sink     scan,
  psa_out_if.source  result
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_full;
  logic       out_valid;
  psa_res_t   out_word;
  psa_res_t   res;
  logic       fire;

  // decode may proceed unless it yields a word and the result register is stuck
  assign fire       = in_valid && (!res.emit || !out_valid || result.ready);
  assign scan.ready = !in_valid || fire;

  psa_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .step        (fire),
    .scan_byte   (in_byte),
    .buffer_full (in_full),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (scan.ready) begin
      in_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.ready) begin
      in_byte <= scan.scan_byte;
      in_full <= scan.buffer_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      out_word <= res;
    end
  end

  assign result.valid       = out_valid;
  assign result.result_kind = out_word.kind;
  assign result.char_code   = out_word.char_code;
  assign result.ctrl_held   = out_word.ctrl_held;
  assign result.alt_held    = out_word.alt_held;

  `ASSERT_NXT(a_emit_loads_output, clk, rst, fire && res.emit, out_valid)
  `ASSERT_NXT(a_pending_word_kept, clk, rst, in_valid && !fire, in_valid && $stable(in_byte))

endmodule
`default_nettype wire

/* rtl/core/psa_keymap.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psa_keymap
// 59 x 2 keymap ROM, lower or upper column.
// ---------------------------------------------------------------------------
module psa_keymap
  import psa_pkg::*;
(
  input  wire logic [5:0] idx,
  input  wire logic       upper,
  output logic      [6:0] ch
);

  always_comb begin
    if (idx < 6'(KEYMAP_DEPTH)) begin
      ch = upper ? KEYMAP_HI[idx] : KEYMAP_LO[idx];
    end else begin
      ch = 7'd0;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/psa_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psa_decode
// Prefix and modifier state plus per-byte decode verdict.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psa_decode
  import psa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] scan_byte,
  input  wire logic       buffer_full,
  output psa_res_t        res
);

  logic extended_pending, ctrl_down, alt_down, shift_down, caps_on;
  logic extended_pending_next, ctrl_down_next, alt_down_next;
  logic shift_down_next, caps_on_next;

  logic       is_prefix, is_break, in_table, shift_only, upper;
  logic       caps_press;
  logic [6:0] low7;
  logic [6:0] ch;

  assign is_prefix = (scan_byte == PREFIX_BYTE);
  assign is_break  = scan_byte[7];
  assign low7      = scan_byte[6:0];

  assign in_table = extended_pending ? (low7 == K_CTRL || low7 == K_ALT)
                                     : (scan_byte != 8'd0 && scan_byte < TABLE_LIMIT);

  // digit and punctuation keys ignore caps lock
  assign shift_only = !extended_pending &&
                      (scan_byte < 8'h0E || scan_byte == 8'h1A || scan_byte == 8'h1B ||
                       scan_byte == 8'h27 || scan_byte == 8'h28 || scan_byte == 8'h29 ||
                       scan_byte == 8'h2B || scan_byte == 8'h33 || scan_byte == 8'h34 ||
                       scan_byte == 8'h35);
  assign upper = shift_only ? shift_down : (shift_down ^ caps_on);

  assign caps_press = !is_prefix && !is_break && in_table && ch == 7'd0 &&
                      low7 == K_CAPS && !extended_pending;

  psa_keymap u_keymap (
    .idx   (scan_byte[5:0]),
    .upper (upper),
    .ch    (ch)
  );

  always_comb begin
    extended_pending_next = 1'b0;
    ctrl_down_next        = ctrl_down;
    alt_down_next         = alt_down;
    shift_down_next       = shift_down;
    caps_on_next          = caps_on;
    res.emit              = 1'b0;
    res.kind              = KIND_CHAR;
    res.char_code         = ch;
    res.ctrl_held         = ctrl_down;
    res.alt_held          = alt_down;

    priority if (is_prefix) begin
      extended_pending_next = 1'b1;
    end else if (is_break) begin
      if (low7 == K_CTRL) begin
        ctrl_down_next = 1'b0;
      end else if (!extended_pending && (low7 == K_SHIFT_L || low7 == K_SHIFT_R)) begin
        shift_down_next = 1'b0;
      end else if (low7 == K_ALT) begin
        alt_down_next = 1'b0;
      end
    end else if (in_table) begin
      if (ch != 7'd0) begin
        res.emit = !buffer_full;
      end else if (low7 == K_CTRL) begin
        ctrl_down_next = 1'b1;
      end else if (low7 == K_ALT) begin
        alt_down_next = 1'b1;
      end else if (low7 == K_SHIFT_L || low7 == K_SHIFT_R) begin
        shift_down_next = 1'b1;
      end else if (low7 == K_CAPS) begin
        caps_on_next = !caps_on;
      end
    end else begin
      res.emit      = 1'b1;
      res.kind      = KIND_UNKNOWN;
      res.char_code = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extended_pending <= 1'b0;
      ctrl_down        <= 1'b0;
      alt_down         <= 1'b0;
      shift_down       <= 1'b0;
      caps_on          <= 1'b0;
    end else if (step) begin
      extended_pending <= extended_pending_next;
      ctrl_down        <= ctrl_down_next;
      alt_down         <= alt_down_next;
      shift_down       <= shift_down_next;
      caps_on          <= caps_on_next;
    end
  end

  `ASSERT_NXT(a_prefix_sets_pending, clk, rst, step && is_prefix, extended_pending)
  `ASSERT_NXT(a_caps_toggles, clk, rst, step && caps_press, caps_on != $past(caps_on))

endmodule
`default_nettype wire

/* bench/ps2_scancode_to_ascii_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ps2_scancode_to_ascii_unit_tb
// Self-checking bench for the scan code set 1 decoder. A behavioural keyboard
// decoder tracks prefix, modifier and caps state for every accepted scan word
// and queues the character or unknown-key words it should produce. A monitor
// compares each result word against the oldest queued one. Stimulus is a
// short directed run followed by random typing with bursty input and a
// stalling result sink.
// ---------------------------------------------------------------------------
module ps2_scancode_to_ascii_unit_tb;
  import psa_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_LEN   = 4;
  localparam int DRAIN_TAIL  = 4;
  localparam int TIMEOUT_NS  = 5_000_000;
  localparam int RANDOM_HALF = 810;

  // scan codes
  localparam logic [7:0]  SC_PREFIX  = 8'hE0;
  localparam logic [7:0]  SC_BREAK   = 8'h80;
  localparam logic [7:0]  SC_ESC     = 8'h01;
  localparam logic [7:0]  SC_CTRL    = 8'h1D;
  localparam logic [7:0]  SC_SHIFT_L = 8'h2A;
  localparam logic [7:0]  SC_SHIFT_R = 8'h36;
  localparam logic [7:0]  SC_ALT     = 8'h38;
  localparam logic [7:0]  SC_SPACE   = 8'h39;
  localparam logic [7:0]  SC_CAPS    = 8'h3A;
  localparam logic [7:0]  SC_FIRST_UNMAPPED = 8'h3B;
  localparam logic [7:0]  SC_LAST_MAKE      = 8'h7F;
  localparam logic [15:0] CODE_CTRL_R = {SC_PREFIX, SC_CTRL};
  localparam logic [15:0] CODE_ALT_R  = {SC_PREFIX, SC_ALT};

  localparam logic [6:0] KEY_PLAIN [59] = '{
    7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2d, 7'h2b, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0d, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
    7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00
  };

  localparam logic [6:0] KEY_SHIFTED [59] = '{
    7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
    7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0d, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
    7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
    7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00
  };

  typedef struct packed {
    logic       kind;
    logic [6:0] ch;
    logic       ctrl;
    logic       alt;
  } key_event_t;

  logic clk = 1'b0;
  logic rst;

  psa_in_if  scan_ch ();
  psa_out_if res_ch ();

  ps2_scancode_to_ascii_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan_ch),
    .result (res_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // decoder state as the keyboard sees it
  logic prefix_seen;
  logic ctrl_flag;
  logic alt_flag;
  logic shift_flag;
  logic caps_flag;

  key_event_t key_events_due[$];
  int         mismatch_count = 0;
  int         scan_words_sent = 0;
  int         burst_left = 0;
  logic [15:0] sink_cycle = '0;

  function automatic logic shift_only_key(input logic [15:0] code);
    return code < 16'h000E ||
           code inside {16'h1A, 16'h1B, 16'h27, 16'h28, 16'h29, 16'h2B,
                        16'h33, 16'h34, 16'h35};
  endfunction

  function automatic void decode_scan_word(input logic [7:0] b, input logic full);
    logic [15:0] code;
    logic [15:0] made;
    logic [7:0]  idx;
    logic        upper;
    logic [6:0]  ch;
    if (b == SC_PREFIX) begin
      prefix_seen = 1'b1;
      return;
    end
    code = {8'h00, b};
    if (prefix_seen) begin
      code[15:8]  = SC_PREFIX;
      prefix_seen = 1'b0;
    end
    if (code[7]) begin
      made = code;
      made[7] = 1'b0;
      if (made == {8'h00, SC_CTRL} || made == CODE_CTRL_R)
        ctrl_flag = 1'b0;
      else if (made == {8'h00, SC_SHIFT_L} || made == {8'h00, SC_SHIFT_R})
        shift_flag = 1'b0;
      else if (made == {8'h00, SC_ALT} || made == CODE_ALT_R)
        alt_flag = 1'b0;
      return;
    end
    if ((code != 16'h0 && code < {8'h00, SC_FIRST_UNMAPPED}) ||
        code == CODE_CTRL_R || code == CODE_ALT_R) begin
      idx   = code[7:0];
      upper = shift_only_key(code) ? shift_flag : (shift_flag ^ caps_flag);
      ch    = upper ? KEY_SHIFTED[idx] : KEY_PLAIN[idx];
      if (ch != 7'h00) begin
        // dropped silently when the character queue is full
        if (!full)
          key_events_due.push_back('{KIND_CHAR, ch, ctrl_flag, alt_flag});
        return;
      end
      case (idx)
        SC_CTRL:             ctrl_flag  = 1'b1;
        SC_ALT:              alt_flag   = 1'b1;
        SC_SHIFT_L,
        SC_SHIFT_R:          shift_flag = 1'b1;
        SC_CAPS:             caps_flag  = ~caps_flag;
        default: ;
      endcase
      return;
    end
    key_events_due.push_back('{KIND_UNKNOWN, 7'h00, ctrl_flag, alt_flag});
  endfunction

  // one scan word; the sender runs in bursts with random gaps in between
  task automatic send_scan(input logic [7:0] b, input logic full);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        scan_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    scan_ch.valid       <= 1'b1;
    scan_ch.scan_byte   <= b;
    scan_ch.buffer_full <= full;
    do @(posedge clk); while (scan_ch.ready !== 1'b1);
    decode_scan_word(b, full);
    scan_words_sent++;
  endtask

  function automatic logic random_full();
    return $urandom_range(0, 7) == 0;
  endfunction

  task automatic tap_key(input logic [7:0] k);
    send_scan(k, random_full());
    send_scan(k | SC_BREAK, random_full());
  endtask

  task automatic wait_drained();
    scan_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (key_events_due.size() != 0);
    // ignored words may still be in the pipe
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic test_plain_keys();
    send_scan(8'h00, 1'b0);
    send_scan(8'hFF, 1'b1);
    send_scan(SC_LAST_MAKE, 1'b1);        // unknown key even with queue full
    send_scan(SC_FIRST_UNMAPPED, 1'b0);
    send_scan(SC_ESC, 1'b0);
    send_scan(SC_SHIFT_L, 1'b0);
    send_scan(8'h10, 1'b0);
    send_scan(8'h02, 1'b0);
    send_scan(SC_SHIFT_L | SC_BREAK, 1'b0);
    send_scan(SC_CAPS, 1'b0);
    send_scan(8'h10, 1'b0);               // caps gives upper case letter
    send_scan(8'h02, 1'b0);               // but not on a digit
    send_scan(8'h1E, 1'b1);               // queue full, dropped
    wait_drained();
  endtask

  task automatic test_extended_modifiers();
    send_scan(SC_PREFIX, 1'b0);
    send_scan(SC_PREFIX, 1'b0);           // repeated prefix
    send_scan(SC_CTRL, 1'b0);
    send_scan(SC_PREFIX, 1'b0);
    send_scan(SC_ALT, 1'b0);
    send_scan(8'h2C, 1'b0);
    send_scan(SC_PREFIX, 1'b0);
    send_scan(SC_CTRL | SC_BREAK, 1'b0);
    send_scan(SC_PREFIX, 1'b0);
    send_scan(SC_ALT | SC_BREAK, 1'b0);
    send_scan(SC_PREFIX, 1'b0);
    send_scan(8'h47, 1'b0);               // extended, not in keymap
    send_scan(SC_CTRL, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_typing(input int n);
    int         stop_at;
    int         pick;
    logic [7:0] mod;
    logic       ext;
    stop_at = scan_words_sent + n;
    while (scan_words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        tap_key(8'($urandom_range(1, SC_CAPS)));
      end else if (pick < 52) begin
        mod = $urandom_range(0, 1) ? SC_SHIFT_L : SC_SHIFT_R;
        send_scan(mod, random_full());
        repeat ($urandom_range(1, 4)) tap_key(8'($urandom_range(1, SC_SPACE)));
        send_scan(mod | SC_BREAK, random_full());
      end else if (pick < 58) begin
        tap_key(SC_CAPS);
      end else if (pick < 68) begin
        mod = $urandom_range(0, 1) ? SC_CTRL : SC_ALT;
        ext = 1'($urandom_range(0, 1));
        if (ext) send_scan(SC_PREFIX, random_full());
        send_scan(mod, random_full());
        tap_key(8'($urandom_range(1, SC_SPACE)));
        if (ext) send_scan(SC_PREFIX, random_full());
        send_scan(mod | SC_BREAK, random_full());
      end else if (pick < 76) begin
        send_scan(SC_PREFIX, random_full());
        send_scan(8'($urandom_range(0, 255)), random_full());
      end else if (pick < 86) begin
        send_scan($urandom_range(0, 7) == 0 ? 8'h00 :
                  8'($urandom_range(SC_FIRST_UNMAPPED, SC_LAST_MAKE)), random_full());
      end else begin
        send_scan(8'($urandom_range(0, 255)), random_full());
      end
    end
  endtask

  // result sink: stall pattern steps through four modes picked by sink_cycle[8:7]
  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 1'b1;
    case (sink_cycle[8:7])
      2'd0:    res_ch.ready <= 1'b1;
      2'd1:    res_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2:    res_ch.ready <= (sink_cycle[2:0] == 3'd0);
      default: res_ch.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin : check_results
    key_event_t want;
    if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (key_events_due.size() == 0) begin
        $error("result word with nothing pending: kind %0d char %0h",
               res_ch.result_kind, res_ch.char_code);
        mismatch_count++;
      end else begin
        want = key_events_due.pop_front();
        if (res_ch.result_kind !== want.kind) begin
          $error("result_kind expected %0h actual %0h", want.kind, res_ch.result_kind);
          mismatch_count++;
        end
        if (res_ch.char_code !== want.ch) begin
          $error("char_code expected %0h actual %0h", want.ch, res_ch.char_code);
          mismatch_count++;
        end
        if (res_ch.ctrl_held !== want.ctrl) begin
          $error("ctrl_held expected %0h actual %0h", want.ctrl, res_ch.ctrl_held);
          mismatch_count++;
        end
        if (res_ch.alt_held !== want.alt) begin
          $error("alt_held expected %0h actual %0h", want.alt, res_ch.alt_held);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $error("timeout with %0d result words outstanding", key_events_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst                 <= 1'b1;
    scan_ch.valid       <= 1'b0;
    scan_ch.scan_byte   <= 8'h00;
    scan_ch.buffer_full <= 1'b0;
    prefix_seen = 1'b0;
    ctrl_flag   = 1'b0;
    alt_flag    = 1'b0;
    shift_flag  = 1'b0;
    caps_flag   = 1'b0;
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_keys();
    test_extended_modifiers();
    test_random_typing(RANDOM_HALF);
    wait_drained();                      // sender holds off until all words are back
    test_random_typing(RANDOM_HALF);

    scan_ch.valid <= 1'b0;
    do @(posedge clk); while (key_events_due.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
    @(negedge clk);
    if (key_events_due.size() != 0) begin
      $error("%0d result words never arrived", key_events_due.size());
    end
    if (mismatch_count == 0 && key_events_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
